/* design/co2fca_pkg.sv */
// Shared types, constants and helper functions for the CO2 frame check and alert block.
// No dependencies; every other design file imports this package.
package co2fca_pkg;

  localparam int WORDS_PER_FRAME = 3;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int TEMP_SPAN   = 1750;
  localparam int TEMP_OFFSET = 450;
  localparam int HUM_SPAN    = 1000;
  localparam int FULL_SCALE  = 65535;

  localparam int TPROD_W = 27;  // 1750 * 65535 < 2**27
  localparam int HPROD_W = 26;  // 1000 * 65535 < 2**26

  // alert levels
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_WARN = 2'd1;
  localparam logic [1:0] LVL_CRIT = 2'd2;

  // notice codes
  localparam logic [1:0] NOTE_NONE  = 2'd0;
  localparam logic [1:0] NOTE_CRIT  = 2'd1;
  localparam logic [1:0] NOTE_WARN  = 2'd2;
  localparam logic [1:0] NOTE_CLEAR = 2'd3;

  // register indexes on the APB port
  localparam logic [1:0] REG_WARN_THR  = 2'd0;
  localparam logic [1:0] REG_CRIT_THR  = 2'd1;
  localparam logic [1:0] REG_CLEAR_THR = 2'd2;
  localparam logic [1:0] REG_COOLDOWN  = 2'd3;

  typedef struct packed {
    logic [15:0] co2_word;
    logic [7:0]  co2_check;
    logic [15:0] temp_word;
    logic [7:0]  temp_check;
    logic [15:0] hum_word;
    logic [7:0]  hum_check;
    logic [31:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic               frame_ok;
    logic               has_data;
    logic [15:0]        co2_ppm;
    logic signed [11:0] temp_c_x10;
    logic [9:0]         humidity_x10;
    logic [1:0]         alert_level;
    logic [1:0]         notice;
  } out_res_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic               ok;
    logic [15:0]        co2;
    logic signed [11:0] temp;
    logic [9:0]         hum;
    logic [31:0]        now;
  } entry_t;

  typedef struct packed {
    logic [15:0] warn_thr;
    logic [15:0] crit_thr;
    logic [15:0] clear_thr;
    logic [31:0] cooldown;
  } cfg_t;

  // one byte through the CRC-8 shift register, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(p / 65535) for p < 2**27 (the TPROD_W input): p = q0*65536 + lo, so
  // p - q0*65535 = lo + q0, which needs at most one correction.
  function automatic logic [10:0] div_full_scale(input logic [TPROD_W-1:0] p);
    logic [10:0] q0;
    logic [16:0] rem;
    q0  = p[TPROD_W-1:16];
    rem = {1'b0, p[15:0]} + 17'(q0);
    if (rem >= 17'(FULL_SCALE)) begin
      return q0 + 11'd1;
    end
    return q0;
  endfunction

endpackage

/* design/co2fca_front.sv */
// Front end: takes frame requests, runs the CRC checks and the scale conversions.
// Depends on co2fca_pkg; feeds co2fca_queue.
module co2fca_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  co2fca_pkg::in_req_t  in_req_i,
  output logic                 ent_valid_o,
  input  logic                 ent_ready_i,
  output co2fca_pkg::entry_t   ent_o
);
  import co2fca_pkg::*;

  logic                      s1_valid_q;
  in_req_t                   s1_req_q;
  logic [7:0]                s1_crc_hi_q [WORDS_PER_FRAME];
  logic [7:0]                crc_hi_d    [WORDS_PER_FRAME];
  logic [TPROD_W-1:0]        s1_prod_t_q, prod_t_d;
  logic [HPROD_W-1:0]        s1_prod_h_q, prod_h_d;
  logic [15:0]               in_words  [WORDS_PER_FRAME];
  logic [15:0]               s1_words  [WORDS_PER_FRAME];
  logic [7:0]                s1_checks [WORDS_PER_FRAME];
  logic [WORDS_PER_FRAME-1:0] word_ok;
  logic                      accept;
  logic [10:0]               temp_q11;
  logic [10:0]               hum_q11;

  assign in_stall_o = s1_valid_q & ~ent_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign in_words[0]  = in_req_i.co2_word;
  assign in_words[1]  = in_req_i.temp_word;
  assign in_words[2]  = in_req_i.hum_word;
  assign s1_words[0]  = s1_req_q.co2_word;
  assign s1_words[1]  = s1_req_q.temp_word;
  assign s1_words[2]  = s1_req_q.hum_word;
  assign s1_checks[0] = s1_req_q.co2_check;
  assign s1_checks[1] = s1_req_q.temp_check;
  assign s1_checks[2] = s1_req_q.hum_check;

  // high byte of CRC and the scale products, on the input ahead of the s1 registers
  always_comb begin
    for (int w = 0; w < WORDS_PER_FRAME; w++) begin
      crc_hi_d[w] = crc8_byte(CRC_INIT, in_words[w][15:8]);
    end
    prod_t_d = TPROD_W'(in_req_i.temp_word) * TPROD_W'(TEMP_SPAN);
    prod_h_d = HPROD_W'(in_req_i.hum_word) * HPROD_W'(HUM_SPAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept | (s1_valid_q & ~ent_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q    <= in_req_i;
      s1_crc_hi_q <= crc_hi_d;
      s1_prod_t_q <= prod_t_d;
      s1_prod_h_q <= prod_h_d;
    end
  end

  // low byte of CRC, compare, and the divide by full scale
  always_comb begin
    for (int w = 0; w < WORDS_PER_FRAME; w++) begin
      word_ok[w] = (crc8_byte(s1_crc_hi_q[w], s1_words[w][7:0]) == s1_checks[w]);
    end
    temp_q11 = div_full_scale(s1_prod_t_q);
    hum_q11  = div_full_scale({1'b0, s1_prod_h_q});
  end

  assign ent_valid_o = s1_valid_q;
  assign ent_o.ok    = &word_ok;
  assign ent_o.co2   = s1_req_q.co2_word;
  assign ent_o.temp  = {1'b0, temp_q11} - 12'(TEMP_OFFSET);
  assign ent_o.hum   = hum_q11[9:0];
  assign ent_o.now   = s1_req_q.now_ms;

endmodule

/* design/co2fca_queue.sv */
// Small FIFO of classified frames between front and back.
// Depends on co2fca_pkg for the entry type.
module co2fca_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  co2fca_pkg::entry_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output co2fca_pkg::entry_t pop_data_o
);
  import co2fca_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

/* design/co2fca_back.sv */
// Back end: latches measurements, runs the alert level and notice logic, holds the result.
// Depends on co2fca_pkg; fed by co2fca_queue.
module co2fca_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  co2fca_pkg::cfg_t     cfg_i,
  input  logic                 ent_valid_i,
  output logic                 ent_ready_o,
  input  co2fca_pkg::entry_t   ent_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output co2fca_pkg::out_res_t out_res_o
);
  import co2fca_pkg::*;

  logic               out_valid_q;
  out_res_t           res_q, res_d;
  logic [1:0]         level_q, level_d, new_level;
  logic [31:0]        warn_stamp_q, warn_stamp_d;
  logic [31:0]        crit_stamp_q, crit_stamp_d;
  logic [15:0]        co2_q, co2_d;
  logic signed [11:0] temp_q, temp_d;
  logic [9:0]         hum_q, hum_d;
  logic               seen_q, seen_d;
  logic [1:0]         note;
  logic               pop;
  logic               crit_due, warn_due;

  assign pop         = ent_valid_i & (~out_valid_q | ~out_stall_i);
  assign ent_ready_o = ~out_valid_q | ~out_stall_i;

  // cooldown elapsed, measured modulo 2**32
  assign crit_due = ((ent_i.now - crit_stamp_q) >= cfg_i.cooldown);
  assign warn_due = ((ent_i.now - warn_stamp_q) >= cfg_i.cooldown);

  always_comb begin
    if (ent_i.co2 >= cfg_i.crit_thr) begin
      new_level = LVL_CRIT;
    end else if (ent_i.co2 >= cfg_i.warn_thr) begin
      new_level = LVL_WARN;
    end else if (ent_i.co2 < cfg_i.clear_thr) begin
      new_level = LVL_NONE;
    end else begin
      new_level = level_q;
    end
  end

  always_comb begin
    level_d      = level_q;
    warn_stamp_d = warn_stamp_q;
    crit_stamp_d = crit_stamp_q;
    co2_d        = co2_q;
    temp_d       = temp_q;
    hum_d        = hum_q;
    seen_d       = seen_q;
    note         = NOTE_NONE;
    if (ent_i.ok) begin
      level_d = new_level;
      co2_d   = ent_i.co2;
      temp_d  = ent_i.temp;
      hum_d   = ent_i.hum;
      seen_d  = 1'b1;
      case (new_level)
        LVL_CRIT: begin
          if (level_q != LVL_CRIT || crit_due) begin
            note         = NOTE_CRIT;
            crit_stamp_d = ent_i.now;
          end
        end
        LVL_WARN: begin
          if (level_q != LVL_WARN || warn_due) begin
            note         = NOTE_WARN;
            warn_stamp_d = ent_i.now;
          end
        end
        default: begin
          if (level_q != LVL_NONE) begin
            note         = NOTE_CLEAR;
            warn_stamp_d = '0;
            crit_stamp_d = '0;
          end
        end
      endcase
    end
    res_d.frame_ok     = ent_i.ok;
    res_d.has_data     = seen_d;
    res_d.co2_ppm      = co2_d;
    res_d.temp_c_x10   = temp_d;
    res_d.humidity_x10 = hum_d;
    res_d.alert_level  = level_d;
    res_d.notice       = note;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      level_q      <= LVL_NONE;
      warn_stamp_q <= '0;
      crit_stamp_q <= '0;
      co2_q        <= '0;
      temp_q       <= '0;
      hum_q        <= '0;
      seen_q       <= 1'b0;
    end else begin
      out_valid_q <= pop | (out_valid_q & out_stall_i);
      if (pop) begin
        level_q      <= level_d;
        warn_stamp_q <= warn_stamp_d;
        crit_stamp_q <= crit_stamp_d;
        co2_q        <= co2_d;
        temp_q       <= temp_d;
        hum_q        <= hum_d;
        seen_q       <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_bad_frame_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.frame_ok) |-> (res_q.notice == NOTE_NONE))
    else $error("notice on a bad frame");

  a_clear_to_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.notice == NOTE_CLEAR) |-> (res_q.alert_level == LVL_NONE))
    else $error("recovery notice with level raised");

  a_notice_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.notice == NOTE_CRIT || res_q.notice == NOTE_WARN)) |->
      ((res_q.notice == NOTE_CRIT) == (res_q.alert_level == LVL_CRIT)))
    else $error("notice does not match level");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (res_q.alert_level == level_q && res_q.has_data == seen_q))
    else $error("result out of step with latched state");

endmodule

/* design/co2_frame_check_and_alert_top.sv */
// CO2 frame check and alert block: top level with the APB register file.
// Depends on co2fca_pkg, co2fca_front, co2fca_queue and co2fca_back.
//
// Path: a request accepted into the front's stage register passes through the queue
//   memory into the back's output register, from which its result is shown.
// Throughput: one request per cycle while neither in_stall_o nor out_stall_i holds;
//   the queue keeps the front running under a stalled output until the queue is full.
// Reset: rst_ni is asynchronous, active low; registers return to warn 1000, crit 2000,
//   clear 800, cooldown 300000, the alert state to none with zeroed stamps and latches.
module co2_frame_check_and_alert_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // frame requests
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  co2fca_pkg::in_req_t  in_req_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output co2fca_pkg::out_res_t out_res_o,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import co2fca_pkg::*;

  cfg_t   cfg_q;
  logic   cfg_wr;
  logic   fq_valid, fq_ready;
  entry_t fq_data;
  logic   qb_valid, qb_ready;
  entry_t qb_data;

  // Register file: word address paddr[3:2], zero wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_thr  <= 16'd1000;
      cfg_q.crit_thr  <= 16'd2000;
      cfg_q.clear_thr <= 16'd800;
      cfg_q.cooldown  <= 32'd300000;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WARN_THR:  cfg_q.warn_thr  <= pwdata[15:0];
        REG_CRIT_THR:  cfg_q.crit_thr  <= pwdata[15:0];
        REG_CLEAR_THR: cfg_q.clear_thr <= pwdata[15:0];
        REG_COOLDOWN:  cfg_q.cooldown  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WARN_THR:  prdata = {16'd0, cfg_q.warn_thr};
      REG_CRIT_THR:  prdata = {16'd0, cfg_q.crit_thr};
      REG_CLEAR_THR: prdata = {16'd0, cfg_q.clear_thr};
      REG_COOLDOWN:  prdata = cfg_q.cooldown;
      default:       prdata = '0;
    endcase
  end

  // Front: CRC check and conversions; stalls only when the queue is full.
  co2fca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .ent_valid_o (fq_valid),
    .ent_ready_i (fq_ready),
    .ent_o       (fq_data)
  );

  // Queue decouples the front from a stalled output.
  co2fca_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  // Back: alert state machine and the output register.
  co2fca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ent_valid_i (qb_valid),
    .ent_ready_o (qb_ready),
    .ent_i       (qb_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule
